>>> rtl/core/ccbc_pkg.sv
// Shared constants and the reflected CRC-8 mask function for the chained byte cipher.
package ccbc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 10;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 8;

  localparam logic [ByteW-1:0] Crc8Poly = 8'h8C;

  localparam logic [CfgIdxW-1:0] RegKey = 1'b0;
  localparam logic [CfgIdxW-1:0] RegDir = 1'b1;

  // Reflected CRC-8 over one byte, zero start, no final xor.
  function automatic logic [ByteW-1:0] crc8_refl(input logic [ByteW-1:0] data);
    logic [ByteW-1:0] crc;
    logic             low;
    crc = '0;
    for (int b = 0; b < ByteW; b++) begin
      low = crc[0];
      crc = crc >> 1;
      if (low) begin
        crc = crc ^ Crc8Poly;
      end
      if (data[b]) begin
        crc = crc ^ Crc8Poly;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/core/crc8_chained_byte_cipher.sv
// Chained byte cipher: CRC-8 masked, position mixed, one byte in and one byte out per transfer.
//
//   channel  dir  ports                              payload
//   in       in   in_tvalid/in_tready/in_tdata/tuser tdata[7:0] in_byte, tuser[0] first
//   out      out  out_tvalid/out_tready/out_tdata    tdata[7:0] out_byte
//   cfg      in   cfg_we/cfg_idx/cfg_wdata           idx 0 cipher_key, idx 1 direction
//
// One byte per cycle while the output is not stalled; the result appears in the cycle after the input transfer.
// Chain byte and position update in the cycle of the input transfer, so the
// next byte may follow immediately.
// Reset (synchronous, active low) clears key, direction, chain and position.
// A stalled result holds in the output register; input is taken whenever
// that register is empty or being drained.
module crc8_chained_byte_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ccbc_pkg::ByteW-1:0]    in_tdata,   // [7:0] in_byte
  input  logic                          in_tuser,   // [0] first
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ccbc_pkg::ByteW-1:0]    out_tdata,  // [7:0] out_byte
  input  logic                          cfg_we,
  input  logic [ccbc_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [ccbc_pkg::CfgW-1:0]     cfg_wdata
);
  import ccbc_pkg::*;

  logic [ByteW-1:0] key_r;
  logic             dir_r;
  logic [ByteW-1:0] chain_r, chain_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [ByteW-1:0] res_r, res_nxt;
  logic             vld_r;

  logic             in_xfer;
  logic [ByteW-1:0] chain_cur;
  logic [PosW-1:0]  pos_cur;
  logic [ByteW-1:0] mask;
  logic [ByteW-1:0] sub;

  assign in_tready  = !vld_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = res_r;

  always_comb begin
    chain_cur = in_tuser ? '0 : chain_r;
    pos_cur   = in_tuser ? '0 : pos_r;
    mask      = crc8_refl(chain_cur);
    sub       = key_r | pos_cur[PosW-1:2];
    if (!dir_r) begin
      res_nxt   = (in_tdata ^ key_r ^ mask) - sub;
      chain_nxt = in_tdata | pos_cur[ByteW-1:0] | key_r;
    end else begin
      res_nxt   = (in_tdata + sub) ^ key_r ^ mask;
      chain_nxt = res_nxt | pos_cur[ByteW-1:0] | key_r;
    end
    pos_nxt = pos_cur + PosW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      dir_r   <= 1'b0;
      chain_r <= '0;
      pos_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          RegKey:  key_r <= cfg_wdata[ByteW-1:0];
          RegDir:  dir_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        chain_r <= chain_nxt;
        pos_r   <= pos_nxt;
        vld_r   <= 1'b1;
      end else if (out_tready) begin
        vld_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/core/ccbc_checker.sv
// Port-level checks for the chained byte cipher, bound to the top level.
module ccbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ccbc_pkg::ByteW-1:0] out_tdata
);

  // A held result keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Every input transfer yields a result in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transfer without result");

  // Input is never blocked while the output register is empty.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // No result without a preceding input transfer.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without input transfer");

endmodule

bind crc8_chained_byte_cipher ccbc_checker u_ccbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
